/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/i2crs_pkg.sv */
// types and constants of the i2c register transaction sequencer
// no dependencies
package i2crs_pkg;

   localparam int MAX_BYTES = 32;
   localparam int BUF_DEPTH = 32;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int STEP_W    = 6;

   typedef enum logic [1:0] {
      OP_LOAD        = 2'd0,
      OP_BEGIN_WRITE = 2'd1,
      OP_BEGIN_READ  = 2'd2,
      OP_COMPLETE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_START     = 3'd0,
      ACT_STOP      = 3'd1,
      ACT_WRITE     = 3'd2,
      ACT_READ      = 3'd3,
      ACT_DATA      = 3'd4,
      ACT_DONE_OK   = 3'd5,
      ACT_DONE_FAIL = 3'd6
   } action_type;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_SIZE = 3'd5;

   localparam logic [3:0] RETRIES_RESET = 4'd10;

   // transaction phase, one-hot
   typedef enum logic [9:0] {
      PH_IDLE    = 10'b00_0000_0001,
      PH_START   = 10'b00_0000_0010,
      PH_ADDR_W  = 10'b00_0000_0100,
      PH_INDEX   = 10'b00_0000_1000,
      PH_DATA_TX = 10'b00_0001_0000,
      PH_SUSPEND = 10'b00_0010_0000,
      PH_RESTART = 10'b00_0100_0000,
      PH_ADDR_R  = 10'b00_1000_0000,
      PH_READ    = 10'b01_0000_0000,
      PH_STOP    = 10'b10_0000_0000
   } phase_type;

   // local sequencing around the buffer memory, one-hot
   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'b001,
      SEQ_FETCH = 3'b010,
      SEQ_DRAIN = 3'b100
   } seq_type;

endpackage

/* hw/rtl/i2crs_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module i2crs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/i2c_register_transaction_sequencer_unit.sv */
// top level of the i2c register transaction sequencer
// depends on i2crs_pkg, i2crs_ram and assert_macros.svh

// A request is taken when start is high and busy is low; each result shows on
// the rsp_ ports for one cycle with rsp_valid high and cannot be held off, so
// the receiver must take it then. A load gives no result; a begin outside a
// transaction and most completions give one result, in the following cycle. A
// completion that sends a buffered write byte holds busy while the byte is
// fetched through the registered read of the byte buffer ram. The completion
// that ends a successful read of n bytes holds busy while the buffer ram is
// walked one byte a cycle, giving n read data results and then done ok.
// rsp_last marks the final result of each request. csr_ready is always high;
// write max_retries only when no transaction is in progress.
module i2c_register_transaction_sequencer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_device_address,
   input  logic [7:0] req_register_index,
   input  logic [7:0] req_byte_count,
   input  logic [4:0] req_buffer_slot,
   input  logic [7:0] req_data_byte,
   input  logic       req_op_ok,
   input  logic [1:0] req_fail_code,
   output logic       rsp_valid,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_send_nack,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_last,
   output logic [2:0] rsp_error_code,
   output logic [3:0] rsp_retries_used,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

`include "assert_macros.svh"

   localparam int AW = i2crs_pkg::BUF_AW;
   localparam int SW = i2crs_pkg::STEP_W;

   i2crs_pkg::seq_type   seq_ff, seq_in;
   i2crs_pkg::phase_type phase_ff, phase_in;
   logic [3:0]    max_retries_ff;
   logic          is_read_ff, is_read_in;
   logic [7:0]    dev_addr_ff, dev_addr_in;
   logic [7:0]    reg_index_ff, reg_index_in;
   logic [SW-1:0] xfer_count_ff, xfer_count_in;
   logic [SW-1:0] xfer_step_ff, xfer_step_in;
   logic [3:0]    retry_count_ff, retry_count_in;
   logic [SW-1:0] drain_cnt_ff, drain_cnt_in;
   logic          drain_pend_ff, drain_pend_in;

   logic          rsp_valid_ff, rsp_valid_in;
   i2crs_pkg::action_type rsp_action_ff, rsp_action_in;
   logic [7:0]    rsp_tx_ff, rsp_tx_in;
   logic          rsp_nack_ff, rsp_nack_in;
   logic [7:0]    rsp_rd_ff, rsp_rd_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [2:0]    rsp_err_ff, rsp_err_in;
   logic [3:0]    rsp_retries_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          accept;
   logic [SW-1:0] step_next;
   logic [2:0]    fail_err;

   assign busy      = (seq_ff != i2crs_pkg::SEQ_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign step_next = xfer_step_ff + SW'(1);
   assign fail_err  = {1'b0, req_fail_code} + 3'd1;

   i2crs_ram #(
      .WIDTH(8),
      .DEPTH(i2crs_pkg::BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      seq_in         = seq_ff;
      phase_in       = phase_ff;
      is_read_in     = is_read_ff;
      dev_addr_in    = dev_addr_ff;
      reg_index_in   = reg_index_ff;
      xfer_count_in  = xfer_count_ff;
      xfer_step_in   = xfer_step_ff;
      retry_count_in = retry_count_ff;
      drain_cnt_in   = drain_cnt_ff;
      drain_pend_in  = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_action_in  = i2crs_pkg::ACT_START;
      rsp_tx_in      = 8'd0;
      rsp_nack_in    = 1'b0;
      rsp_rd_in      = 8'd0;
      rsp_last_in    = 1'b1;
      rsp_err_in     = i2crs_pkg::ERR_NONE;
      ram_we         = 1'b0;
      ram_waddr      = req_buffer_slot;
      ram_wdata      = req_data_byte;
      ram_raddr      = xfer_step_ff[AW-1:0];

      unique case (seq_ff)
         i2crs_pkg::SEQ_IDLE: begin
            if (accept) begin
               unique case (i2crs_pkg::opcode_type'(req_opcode))
                  i2crs_pkg::OP_LOAD: begin
                     ram_we = (phase_ff == i2crs_pkg::PH_IDLE);
                  end
                  i2crs_pkg::OP_BEGIN_WRITE, i2crs_pkg::OP_BEGIN_READ: begin
                     if (phase_ff == i2crs_pkg::PH_IDLE) begin
                        retry_count_in = 4'd0;
                        rsp_valid_in   = 1'b1;
                        if (req_byte_count > 8'(i2crs_pkg::MAX_BYTES)) begin
                           rsp_action_in = i2crs_pkg::ACT_DONE_FAIL;
                           rsp_err_in    = i2crs_pkg::ERR_SIZE;
                        end else begin
                           is_read_in    = (req_opcode == i2crs_pkg::OP_BEGIN_READ);
                           dev_addr_in   = req_device_address;
                           reg_index_in  = req_register_index;
                           xfer_count_in = req_byte_count[SW-1:0];
                           xfer_step_in  = '0;
                           phase_in      = i2crs_pkg::PH_START;
                           rsp_action_in = i2crs_pkg::ACT_START;
                        end
                     end
                  end
                  i2crs_pkg::OP_COMPLETE: begin
                     if (phase_ff != i2crs_pkg::PH_IDLE) begin
                        if (req_op_ok) begin
                           rsp_valid_in = 1'b1;
                           unique case (phase_ff)
                              i2crs_pkg::PH_START: begin
                                 rsp_action_in = i2crs_pkg::ACT_WRITE;
                                 rsp_tx_in     = dev_addr_ff;
                                 phase_in      = i2crs_pkg::PH_ADDR_W;
                              end
                              i2crs_pkg::PH_ADDR_W: begin
                                 rsp_action_in = i2crs_pkg::ACT_WRITE;
                                 rsp_tx_in     = reg_index_ff;
                                 phase_in      = i2crs_pkg::PH_INDEX;
                              end
                              i2crs_pkg::PH_INDEX, i2crs_pkg::PH_DATA_TX: begin
                                 if (phase_ff == i2crs_pkg::PH_INDEX && is_read_ff) begin
                                    rsp_action_in = i2crs_pkg::ACT_STOP;
                                    phase_in      = i2crs_pkg::PH_SUSPEND;
                                 end else if (xfer_step_ff < xfer_count_ff) begin
                                    // byte comes from the registered ram read in the fetch state
                                    rsp_valid_in = 1'b0;
                                    xfer_step_in = step_next;
                                    phase_in     = i2crs_pkg::PH_DATA_TX;
                                    seq_in       = i2crs_pkg::SEQ_FETCH;
                                 end else begin
                                    rsp_action_in = i2crs_pkg::ACT_STOP;
                                    phase_in      = i2crs_pkg::PH_STOP;
                                 end
                              end
                              i2crs_pkg::PH_SUSPEND: begin
                                 rsp_action_in = i2crs_pkg::ACT_START;
                                 phase_in      = i2crs_pkg::PH_RESTART;
                              end
                              i2crs_pkg::PH_RESTART: begin
                                 rsp_action_in = i2crs_pkg::ACT_WRITE;
                                 rsp_tx_in     = dev_addr_ff | 8'h01;
                                 phase_in      = i2crs_pkg::PH_ADDR_R;
                              end
                              i2crs_pkg::PH_ADDR_R: begin
                                 xfer_step_in = '0;
                                 if (xfer_count_ff != '0) begin
                                    rsp_action_in = i2crs_pkg::ACT_READ;
                                    rsp_nack_in   = (xfer_count_ff == SW'(1));
                                    phase_in      = i2crs_pkg::PH_READ;
                                 end else begin
                                    rsp_action_in = i2crs_pkg::ACT_STOP;
                                    phase_in      = i2crs_pkg::PH_STOP;
                                 end
                              end
                              i2crs_pkg::PH_READ: begin
                                 ram_we       = 1'b1;
                                 ram_waddr    = xfer_step_ff[AW-1:0];
                                 xfer_step_in = step_next;
                                 if (step_next < xfer_count_ff) begin
                                    rsp_action_in = i2crs_pkg::ACT_READ;
                                    rsp_nack_in   = ({1'b0, step_next} + (SW+1)'(1))
                                                    == {1'b0, xfer_count_ff};
                                 end else begin
                                    rsp_action_in = i2crs_pkg::ACT_STOP;
                                    phase_in      = i2crs_pkg::PH_STOP;
                                 end
                              end
                              i2crs_pkg::PH_STOP: begin
                                 phase_in = i2crs_pkg::PH_IDLE;
                                 if (is_read_ff && xfer_count_ff != '0) begin
                                    rsp_valid_in = 1'b0;
                                    drain_cnt_in = '0;
                                    seq_in       = i2crs_pkg::SEQ_DRAIN;
                                 end else begin
                                    rsp_action_in = i2crs_pkg::ACT_DONE_OK;
                                 end
                              end
                              default: begin
                                 rsp_valid_in = 1'b0;
                                 phase_in     = i2crs_pkg::PH_IDLE;
                              end
                           endcase
                        end else if (retry_count_ff < max_retries_ff) begin
                           retry_count_in = retry_count_ff + 4'd1;
                           xfer_step_in   = '0;
                           phase_in       = i2crs_pkg::PH_START;
                           rsp_valid_in   = 1'b1;
                           rsp_action_in  = i2crs_pkg::ACT_START;
                           rsp_err_in     = fail_err;
                        end else begin
                           phase_in      = i2crs_pkg::PH_IDLE;
                           rsp_valid_in  = 1'b1;
                           rsp_action_in = i2crs_pkg::ACT_DONE_FAIL;
                           rsp_err_in    = fail_err;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         i2crs_pkg::SEQ_FETCH: begin
            rsp_valid_in  = 1'b1;
            rsp_action_in = i2crs_pkg::ACT_WRITE;
            rsp_tx_in     = ram_rdata;
            seq_in        = i2crs_pkg::SEQ_IDLE;
         end
         i2crs_pkg::SEQ_DRAIN: begin
            ram_raddr = drain_cnt_ff[AW-1:0];
            if (drain_cnt_ff < xfer_count_ff) begin
               drain_cnt_in  = drain_cnt_ff + SW'(1);
               drain_pend_in = 1'b1;
            end
            if (drain_pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = i2crs_pkg::ACT_DATA;
               rsp_rd_in     = ram_rdata;
               rsp_last_in   = 1'b0;
            end else if (drain_cnt_ff >= xfer_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = i2crs_pkg::ACT_DONE_OK;
               seq_in        = i2crs_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = i2crs_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= i2crs_pkg::SEQ_IDLE;
         phase_ff       <= i2crs_pkg::PH_IDLE;
         max_retries_ff <= i2crs_pkg::RETRIES_RESET;
         is_read_ff     <= 1'b0;
         retry_count_ff <= 4'd0;
         xfer_step_ff   <= '0;
         xfer_count_ff  <= '0;
         drain_pend_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seq_ff         <= seq_in;
         phase_ff       <= phase_in;
         is_read_ff     <= is_read_in;
         retry_count_ff <= retry_count_in;
         xfer_step_ff   <= xfer_step_in;
         xfer_count_ff  <= xfer_count_in;
         drain_pend_ff  <= drain_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_retries_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dev_addr_ff    <= dev_addr_in;
      reg_index_ff   <= reg_index_in;
      drain_cnt_ff   <= drain_cnt_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_tx_ff      <= rsp_tx_in;
      rsp_nack_ff    <= rsp_nack_in;
      rsp_rd_ff      <= rsp_rd_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_retries_ff <= retry_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_tx_byte      = rsp_tx_ff;
   assign rsp_send_nack    = rsp_nack_ff;
   assign rsp_read_byte    = rsp_rd_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_error_code   = rsp_err_ff;
   assign rsp_retries_used = rsp_retries_ff;

   // read-out data only appears while the buffer walk holds the block busy
   `ASSERT_IMPLY(a_data_while_drain, clock, reset, rsp_valid && rsp_action == i2crs_pkg::ACT_DATA, seq_ff == i2crs_pkg::SEQ_DRAIN)
   // a buffered write byte is always delivered the cycle after the fetch
   `ASSERT_NEXT(a_fetch_delivers, clock, reset, seq_ff == i2crs_pkg::SEQ_FETCH, rsp_valid && rsp_action == i2crs_pkg::ACT_WRITE && rsp_last)
   // the transaction has already closed when the walk runs
   `ASSERT_IMPLY(a_drain_phase_idle, clock, reset, seq_ff == i2crs_pkg::SEQ_DRAIN, phase_ff == i2crs_pkg::PH_IDLE)
   // a failure report leaves nothing in flight
   `ASSERT_IMPLY(a_fail_ends, clock, reset, rsp_valid && rsp_action == i2crs_pkg::ACT_DONE_FAIL, !busy && phase_ff == i2crs_pkg::PH_IDLE)
   // the walk never runs past the transfer count
   `ASSERT_NEVER(a_drain_bound, clock, reset, seq_ff == i2crs_pkg::SEQ_DRAIN && drain_cnt_ff > xfer_count_ff)

endmodule
